// ===== rtl/core/eight_bit_alu_with_flags_core_macros.svh =====
// Assertion macros shared by the eight-bit ALU core.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_CORE_MACROS_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define EBA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define EBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/eba_pkg.sv =====
// Types, operation codes and flag positions of the eight-bit ALU core.
`timescale 1ns / 1ps

package eba_pkg;

   // Flag bit positions inside the 4-bit flag word
   localparam int unsigned FLAG_Z = 3;
   localparam int unsigned FLAG_N = 2;
   localparam int unsigned FLAG_H = 1;
   localparam int unsigned FLAG_C = 0;

   localparam int unsigned FLAG_WIDTH = 4;

   // Operation codes
   typedef enum logic [4:0] {
      CMD_ADD   = 5'd0,
      CMD_ADC   = 5'd1,
      CMD_SUB   = 5'd2,
      CMD_SBC   = 5'd3,
      CMD_AND   = 5'd4,
      CMD_XOR   = 5'd5,
      CMD_OR    = 5'd6,
      CMD_CP    = 5'd7,
      CMD_INC8  = 5'd8,
      CMD_DEC8  = 5'd9,
      CMD_RLC   = 5'd10,
      CMD_RRC   = 5'd11,
      CMD_RL    = 5'd12,
      CMD_RR    = 5'd13,
      CMD_SLA   = 5'd14,
      CMD_SRA   = 5'd15,
      CMD_SRL   = 5'd16,
      CMD_SWAP  = 5'd17,
      CMD_BIT   = 5'd18,
      CMD_RES   = 5'd19,
      CMD_SET   = 5'd20,
      CMD_DAA   = 5'd21,
      CMD_RLCA  = 5'd22,
      CMD_RLA   = 5'd23,
      CMD_RRCA  = 5'd24,
      CMD_RRA   = 5'd25,
      CMD_ADD16 = 5'd26,
      CMD_INC16 = 5'd27,
      CMD_DEC16 = 5'd28
   } cmd_type;

   // Request payload
   typedef struct packed {
      logic [4:0]  cmd;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [2:0]  bit_index;
   } req_type;

   // Response payload
   typedef struct packed {
      logic [15:0]           result_value;
      logic [FLAG_WIDTH-1:0] flags_out;
   } rsp_type;

endpackage

// ===== rtl/core/eba_alu.sv =====
// Combinational datapath: result value and new flags for one request.
`timescale 1ns / 1ps

module eba_alu (
   input  eba_pkg::req_type                       req,
   input  logic [eba_pkg::FLAG_WIDTH-1:0]         flags_cur,
   output eba_pkg::rsp_type                       rsp
);

   logic [7:0]  a;
   logic [7:0]  b;
   logic [15:0] a16;
   logic        cin;
   logic        t;
   logic [8:0]  sum9;
   logic [4:0]  half_sum;
   logic [8:0]  diff9;
   logic [4:0]  half_diff;
   logic [16:0] sum17;
   logic [12:0] half_sum13;
   logic [7:0]  bit_mask;
   logic [7:0]  r8;
   logic [15:0] r16;
   logic        use16;
   logic [3:0]  f;
   logic        zero8;

   // DAA signals
   logic [3:0]  lo;
   logic [3:0]  hi;
   logic        dn;
   logic        dh;
   logic        dc;
   logic [7:0]  daa_add;
   logic        daa_cout;
   logic [7:0]  daa_res;

   assign a     = req.operand_a[7:0];
   assign b     = req.operand_b[7:0];
   assign a16   = req.operand_a;
   assign cin   = flags_cur[eba_pkg::FLAG_C];

   // Carry-in only for adc and sbc
   assign t = (req.cmd == eba_pkg::CMD_ADC || req.cmd == eba_pkg::CMD_SBC) ? cin : 1'b0;

   // Shared adders
   assign sum9       = {1'b0, a} + {1'b0, b} + {8'd0, t};
   assign half_sum   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
   assign diff9      = {1'b0, a} - {1'b0, b} - {8'd0, t};
   assign half_diff  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
   assign sum17      = {1'b0, a16} + {1'b0, req.operand_b};
   assign half_sum13 = {1'b0, a16[11:0]} + {1'b0, req.operand_b[11:0]};
   assign bit_mask   = 8'd1 << req.bit_index;

   // Decimal adjust lookup on the kept N, H and C
   assign lo = a[3:0];
   assign hi = a[7:4];
   assign dn = flags_cur[eba_pkg::FLAG_N];
   assign dh = flags_cur[eba_pkg::FLAG_H];
   assign dc = flags_cur[eba_pkg::FLAG_C];

   always_comb begin
      daa_add  = 8'h00;
      daa_cout = 1'b0;
      priority if (!dn && !dc) begin
         priority if (!dh && hi <= 4'd8 && lo >= 4'd10) begin
            daa_add = 8'h06;
         end else if (dh && hi <= 4'd9 && lo <= 4'd3) begin
            daa_add = 8'h06;
         end else if (!dh && hi >= 4'd10 && lo <= 4'd9) begin
            daa_add  = 8'h60;
            daa_cout = 1'b1;
         end else if (!dh && hi >= 4'd9 && lo >= 4'd10) begin
            daa_add  = 8'h66;
            daa_cout = 1'b1;
         end else if (dh && hi >= 4'd10 && lo <= 4'd3) begin
            daa_add  = 8'h66;
            daa_cout = 1'b1;
         end else begin
            daa_add = 8'h00;
         end
      end else if (!dn && dc) begin
         priority if (!dh && hi <= 4'd2 && lo <= 4'd9) begin
            daa_add  = 8'h60;
            daa_cout = 1'b1;
         end else if (!dh && hi <= 4'd2 && lo >= 4'd10) begin
            daa_add  = 8'h66;
            daa_cout = 1'b1;
         end else if (dh && hi <= 4'd3 && lo <= 4'd3) begin
            daa_add  = 8'h66;
            daa_cout = 1'b1;
         end else begin
            daa_add = 8'h00;
         end
      end else if (dn && !dc) begin
         if (dh && hi <= 4'd8 && lo >= 4'd6) begin
            daa_add = 8'hFA;
         end
      end else begin
         priority if (!dh && hi >= 4'd7 && lo <= 4'd9) begin
            daa_add  = 8'hA0;
            daa_cout = 1'b1;
         end else if (dh && hi >= 4'd6 && lo >= 4'd6) begin
            daa_add  = 8'h9A;
            daa_cout = 1'b1;
         end else begin
            daa_add = 8'h00;
         end
      end
   end

   assign daa_res = a + daa_add;

   // Select result and flags per operation
   always_comb begin
      r8    = 8'h00;
      r16   = a16;
      use16 = 1'b1;
      f     = flags_cur;
      unique case (req.cmd)
         eba_pkg::CMD_ADD, eba_pkg::CMD_ADC: begin
            r8    = sum9[7:0];
            use16 = 1'b0;
            f     = {(sum9[7:0] == 8'h00), 1'b0, half_sum[4], sum9[8]};
         end
         eba_pkg::CMD_SUB, eba_pkg::CMD_SBC: begin
            r8    = diff9[7:0];
            use16 = 1'b0;
            f     = {(diff9[7:0] == 8'h00), 1'b1, half_diff[4], diff9[8]};
         end
         eba_pkg::CMD_CP: begin
            f = {(diff9[7:0] == 8'h00), 1'b1, half_diff[4], diff9[8]};
         end
         eba_pkg::CMD_AND: begin
            r8    = a & b;
            use16 = 1'b0;
            f     = {((a & b) == 8'h00), 1'b0, 1'b1, 1'b0};
         end
         eba_pkg::CMD_XOR: begin
            r8    = a ^ b;
            use16 = 1'b0;
            f     = {((a ^ b) == 8'h00), 3'b000};
         end
         eba_pkg::CMD_OR: begin
            r8    = a | b;
            use16 = 1'b0;
            f     = {((a | b) == 8'h00), 3'b000};
         end
         eba_pkg::CMD_INC8: begin
            r8    = a + 8'd1;
            use16 = 1'b0;
            f     = {(a == 8'hFF), 1'b0, (a[3:0] == 4'hF), cin};
         end
         eba_pkg::CMD_DEC8: begin
            r8    = a - 8'd1;
            use16 = 1'b0;
            f     = {(a == 8'h01), 1'b1, (a[3:0] == 4'h0), cin};
         end
         eba_pkg::CMD_RLC, eba_pkg::CMD_RLCA: begin
            r8    = {a[6:0], a[7]};
            use16 = 1'b0;
            f     = {(a == 8'h00) && (req.cmd == eba_pkg::CMD_RLC), 2'b00, a[7]};
         end
         eba_pkg::CMD_RRC, eba_pkg::CMD_RRCA: begin
            r8    = {a[0], a[7:1]};
            use16 = 1'b0;
            f     = {(a == 8'h00) && (req.cmd == eba_pkg::CMD_RRC), 2'b00, a[0]};
         end
         eba_pkg::CMD_RL, eba_pkg::CMD_RLA: begin
            r8    = {a[6:0], cin};
            use16 = 1'b0;
            f     = {({a[6:0], cin} == 8'h00) && (req.cmd == eba_pkg::CMD_RL), 2'b00, a[7]};
         end
         eba_pkg::CMD_RR, eba_pkg::CMD_RRA: begin
            r8    = {cin, a[7:1]};
            use16 = 1'b0;
            f     = {({cin, a[7:1]} == 8'h00) && (req.cmd == eba_pkg::CMD_RR), 2'b00, a[0]};
         end
         eba_pkg::CMD_SLA: begin
            r8    = {a[6:0], 1'b0};
            use16 = 1'b0;
            f     = {(a[6:0] == 7'd0), 2'b00, a[7]};
         end
         eba_pkg::CMD_SRA: begin
            r8    = {a[7], a[7:1]};
            use16 = 1'b0;
            f     = {(a[7:1] == 7'd0), 2'b00, a[0]};
         end
         eba_pkg::CMD_SRL: begin
            r8    = {1'b0, a[7:1]};
            use16 = 1'b0;
            f     = {(a[7:1] == 7'd0), 2'b00, a[0]};
         end
         eba_pkg::CMD_SWAP: begin
            r8    = {a[3:0], a[7:4]};
            use16 = 1'b0;
            f     = {(a == 8'h00), 3'b000};
         end
         eba_pkg::CMD_BIT: begin
            f = {((a & bit_mask) == 8'h00), 1'b0, 1'b1, cin};
         end
         eba_pkg::CMD_RES: begin
            r8    = a & ~bit_mask;
            use16 = 1'b0;
         end
         eba_pkg::CMD_SET: begin
            r8    = a | bit_mask;
            use16 = 1'b0;
         end
         eba_pkg::CMD_DAA: begin
            r8    = daa_res;
            use16 = 1'b0;
            f     = {(daa_res == 8'h00), dn, 1'b0, daa_cout};
         end
         eba_pkg::CMD_ADD16: begin
            r16 = sum17[15:0];
            f   = {flags_cur[eba_pkg::FLAG_Z], 1'b0, half_sum13[12], sum17[16]};
         end
         eba_pkg::CMD_INC16: begin
            r16 = a16 + 16'd1;
         end
         eba_pkg::CMD_DEC16: begin
            r16 = a16 - 16'd1;
         end
         default: begin
            // Unused codes: pass operand through, keep flags
            r16 = a16;
         end
      endcase
   end

   assign zero8 = 1'b0;
   assign rsp.result_value = use16 ? r16 : {8'h00, r8};
   assign rsp.flags_out    = f | {eba_pkg::FLAG_WIDTH{zero8}};

endmodule

// ===== rtl/core/eight_bit_alu_with_flags_core.sv =====
// A request passes through the input register, then the result register.
// One request per cycle while the response side is not stalled; the flag register feeds the next request directly.
// The only datapath loop is flag register -> ALU -> flag register.
// Reset (synchronous, active high) clears both valid bits and the flags to zero.
// A response may wait under stall while the next request is accepted into the input register.
`timescale 1ns / 1ps
`include "eight_bit_alu_with_flags_core_macros.svh"

module eight_bit_alu_with_flags_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  eba_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output eba_pkg::rsp_type rsp_payload
);

   eba_pkg::req_type                   req_ff;
   logic                               req_valid_ff;
   logic                               req_valid_in;
   eba_pkg::rsp_type                   rsp_ff;
   eba_pkg::rsp_type                   rsp_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [eba_pkg::FLAG_WIDTH-1:0]     flag_bits_ff;
   logic                               req_accept;
   logic                               stage_go;

   // Advance the input stage when the result register is free or being drained
   assign stage_go   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = req_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   eba_alu u_alu (
      .req       (req_ff),
      .flags_cur (flag_bits_ff),
      .rsp       (rsp_in)
   );

   assign req_valid_in = req_accept || (req_valid_ff && !stage_go);
   assign rsp_valid_in = stage_go || (rsp_valid_ff && rsp_stall);

   // Hold or advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flag_bits_ff <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (stage_go) begin
            flag_bits_ff <= rsp_in.flags_out;
         end
      end
   end

   // Capture request and result payloads
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_payload;
      end
      if (stage_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Checks
   `EBA_ASSERT_NEXT(a_flags_hold, clock, reset, !stage_go, $stable(flag_bits_ff), "flags changed without a request")
   `EBA_ASSERT_SAME(a_flags_match, clock, reset, rsp_valid_ff, rsp_ff.flags_out == flag_bits_ff, "response flags differ from kept flags")
   `EBA_ASSERT_NEXT(a_go_fills, clock, reset, stage_go, rsp_valid_ff, "advanced request did not reach the result register")

endmodule

// ===== bench/eight_bit_alu_with_flags_core_checker.sv =====
// Checker for the eight-bit ALU core: flag-tracking predictor and response scoreboard.
`timescale 1ns / 1ps

module eight_bit_alu_with_flags_core_checker
   import eba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      outstanding
);

   // Flags as the block should hold them after the last accepted request
   logic [3:0] flag_state;
   rsp_type    alu_results_due[$];

   // Compute the response and new flags of one request
   function automatic rsp_type predict_alu_op(input req_type rq, input logic [3:0] fl);
      int unsigned a, b, a16, b16, t;
      logic [7:0]  a8, v, adj;
      logic [15:0] r;
      logic [3:0]  f, lo, hi;
      logic        cin, cout, n, h;
      rsp_type     rs;
      a8   = rq.operand_a[7:0];
      a    = a8;
      b    = rq.operand_b[7:0];
      a16  = rq.operand_a;
      b16  = rq.operand_b;
      cin  = fl[FLAG_C];
      n    = fl[FLAG_N];
      h    = fl[FLAG_H];
      lo   = a8[3:0];
      hi   = a8[7:4];
      t    = 0;
      adj  = 8'h00;
      cout = 1'b0;
      f    = fl;
      r    = rq.operand_a;
      case (rq.cmd)
         CMD_ADD, CMD_ADC: begin
            if (rq.cmd == CMD_ADC) t = cin;
            v = 8'(a + b + t);
            r = {8'h00, v};
            f = {v == 8'h00, 1'b0, ((a & 15) + (b & 15) + t) > 15, (a + b + t) > 255};
         end
         CMD_SUB, CMD_SBC, CMD_CP: begin
            if (rq.cmd == CMD_SBC) t = cin;
            v = 8'(a - b - t);
            r = {8'h00, v};
            f = {v == 8'h00, 1'b1, (a & 15) < ((b & 15) + t), a < (b + t)};
            // compare leaves the operand untouched
            if (rq.cmd == CMD_CP) r = rq.operand_a;
         end
         CMD_AND: begin
            v = a8 & rq.operand_b[7:0];
            r = {8'h00, v};
            f = {v == 8'h00, 3'b010};
         end
         CMD_XOR: begin
            v = a8 ^ rq.operand_b[7:0];
            r = {8'h00, v};
            f = {v == 8'h00, 3'b000};
         end
         CMD_OR: begin
            v = a8 | rq.operand_b[7:0];
            r = {8'h00, v};
            f = {v == 8'h00, 3'b000};
         end
         CMD_INC8: begin
            v = a8 + 8'd1;
            r = {8'h00, v};
            f = {v == 8'h00, 1'b0, lo == 4'hF, cin};
         end
         CMD_DEC8: begin
            v = a8 - 8'd1;
            r = {8'h00, v};
            f = {v == 8'h00, 1'b1, lo == 4'h0, cin};
         end
         CMD_RLC, CMD_RLCA: begin
            v = {a8[6:0], a8[7]};
            r = {8'h00, v};
            f = {(rq.cmd == CMD_RLC) && (v == 8'h00), 2'b00, a8[7]};
         end
         CMD_RRC, CMD_RRCA: begin
            v = {a8[0], a8[7:1]};
            r = {8'h00, v};
            f = {(rq.cmd == CMD_RRC) && (v == 8'h00), 2'b00, a8[0]};
         end
         CMD_RL, CMD_RLA: begin
            v = {a8[6:0], cin};
            r = {8'h00, v};
            f = {(rq.cmd == CMD_RL) && (v == 8'h00), 2'b00, a8[7]};
         end
         CMD_RR, CMD_RRA: begin
            v = {cin, a8[7:1]};
            r = {8'h00, v};
            f = {(rq.cmd == CMD_RR) && (v == 8'h00), 2'b00, a8[0]};
         end
         CMD_SLA: begin
            v = {a8[6:0], 1'b0};
            r = {8'h00, v};
            f = {v == 8'h00, 2'b00, a8[7]};
         end
         CMD_SRA: begin
            v = {a8[7], a8[7:1]};
            r = {8'h00, v};
            f = {v == 8'h00, 2'b00, a8[0]};
         end
         CMD_SRL: begin
            v = {1'b0, a8[7:1]};
            r = {8'h00, v};
            f = {v == 8'h00, 2'b00, a8[0]};
         end
         CMD_SWAP: begin
            v = {a8[3:0], a8[7:4]};
            r = {8'h00, v};
            f = {v == 8'h00, 3'b000};
         end
         CMD_BIT: begin
            f = {~a8[rq.bit_index], 1'b0, 1'b1, cin};
         end
         CMD_RES: r = {8'h00, a8 & ~(8'h01 << rq.bit_index)};
         CMD_SET: r = {8'h00, a8 | (8'h01 << rq.bit_index)};
         CMD_DAA: begin
            // correction table, split on N then C; unlisted patterns add nothing
            if (!n) begin
               if (!cin) begin
                  if (!h && hi <= 8 && lo >= 10) adj = 8'h06;
                  else if (h && hi <= 9 && lo <= 3) adj = 8'h06;
                  else if (!h && hi >= 10 && lo <= 9) begin
                     adj = 8'h60;
                     cout = 1'b1;
                  end else if (!h && hi >= 9 && lo >= 10) begin
                     adj = 8'h66;
                     cout = 1'b1;
                  end else if (h && hi >= 10 && lo <= 3) begin
                     adj = 8'h66;
                     cout = 1'b1;
                  end
               end else begin
                  if (!h && hi <= 2 && lo <= 9) begin
                     adj = 8'h60;
                     cout = 1'b1;
                  end else if (!h && hi <= 2 && lo >= 10) begin
                     adj = 8'h66;
                     cout = 1'b1;
                  end else if (h && hi <= 3 && lo <= 3) begin
                     adj = 8'h66;
                     cout = 1'b1;
                  end
               end
            end else begin
               if (!cin) begin
                  if (h && hi <= 8 && lo >= 6) adj = 8'hFA;
               end else begin
                  if (!h && hi >= 7 && lo <= 9) begin
                     adj = 8'hA0;
                     cout = 1'b1;
                  end else if (h && hi >= 6 && lo >= 6) begin
                     adj = 8'h9A;
                     cout = 1'b1;
                  end
               end
            end
            v = a8 + adj;
            r = {8'h00, v};
            f = {v == 8'h00, n, 1'b0, cout};
         end
         CMD_ADD16: begin
            r = 16'(a16 + b16);
            f = {fl[FLAG_Z], 1'b0, ((a16 & 32'h0FFF) + (b16 & 32'h0FFF)) > 32'h0FFF,
                 (a16 + b16) > 32'hFFFF};
         end
         CMD_INC16: r = rq.operand_a + 16'd1;
         CMD_DEC16: r = rq.operand_a - 16'd1;
         default: r = rq.operand_a;
      endcase
      rs.result_value = r;
      rs.flags_out    = f;
      return rs;
   endfunction

   // Score responses against the oldest prediction, then predict new requests
   always @(posedge clock) begin : score
      rsp_type want;
      if (reset) begin
         alu_results_due.delete();
         flag_state = '0;
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (alu_results_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response, expected none, got %h",
                        $time, rsp_payload);
            end else begin
               want = alu_results_due.pop_front();
               if (rsp_payload.result_value !== want.result_value) begin
                  fail_count++;
                  $display("%0t: result_value expected %h, got %h",
                           $time, want.result_value, rsp_payload.result_value);
               end
               if (rsp_payload.flags_out !== want.flags_out) begin
                  fail_count++;
                  $display("%0t: flags_out expected %b, got %b",
                           $time, want.flags_out, rsp_payload.flags_out);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = predict_alu_op(req_payload, flag_state);
            flag_state = want.flags_out;
            alu_results_due.push_back(want);
         end
      end
      outstanding = alu_results_due.size();
   end

endmodule

// ===== bench/tb_eight_bit_alu_with_flags_core.sv =====
// Testbench top for the eight-bit ALU core: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_eight_bit_alu_with_flags_core;
   import eba_pkg::*;

   localparam logic [4:0] CMD_SPARE_FIRST = 5'd29;
   localparam logic [4:0] CMD_SPARE_LAST  = 5'd31;
   localparam int HOLD_OFF_CYCLES = 40;
   localparam int DRAIN_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT  = 1000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   int fail_count;
   int outstanding;
   int send_idle_pct = 28;
   int recv_idle_pct = 47;
   int hold_off_requests = 0;
   int hold_off_served = 0;
   int hold_off_left = 0;
   int quiet_cycles = 0;

   eight_bit_alu_with_flags_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   eight_bit_alu_with_flags_core_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the response side at random, or hold off for a long stretch on request
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else if (hold_off_served != hold_off_requests) begin
         rsp_stall <= 1'b1;
         hold_off_served <= hold_off_requests;
         hold_off_left <= HOLD_OFF_CYCLES - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request after a random gap and hold it until accepted
   task automatic send_op(input logic [4:0] cmd, input logic [15:0] a,
                          input logic [15:0] b, input logic [2:0] idx);
      req_type rq;
      logic    taken;
      rq.cmd       = cmd;
      rq.operand_a = a;
      rq.operand_b = b;
      rq.bit_index = idx;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= rq;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
         @(negedge clock);
      end
   endtask

   // Favor the edge values of the low byte, keep the upper byte random except in the all-zero and all-one picks
   function automatic logic [15:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return {8'($urandom), 8'h0F};
         3: return {8'($urandom), 8'h80};
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_bcd();
      return 8'(($urandom_range(0, 9) << 4) + $urandom_range(0, 9));
   endfunction

   // Mix random operations with decimal add or subtract followed by an adjust
   task automatic run_random_phase(input int items);
      int         done;
      logic [7:0] x, y, sum;
      done = 0;
      while (done < items) begin
         if ($urandom_range(0, 3) == 0) begin
            x = pick_bcd();
            y = pick_bcd();
            if ($urandom_range(0, 1) == 1) begin
               send_op(CMD_ADD, {8'($urandom), x}, {8'($urandom), y}, 3'($urandom));
               sum = x + y;
            end else begin
               send_op(CMD_SUB, {8'($urandom), x}, {8'($urandom), y}, 3'($urandom));
               sum = x - y;
            end
            send_op(CMD_DAA, {8'($urandom), sum}, pick_operand(), 3'($urandom));
            done += 2;
         end else begin
            send_op(5'($urandom_range(0, 31)), pick_operand(), pick_operand(),
                    3'($urandom_range(0, 7)));
            done++;
         end
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed: every operation at its edges, flags chained where they matter
      send_op(CMD_ADD,   16'h00FF, 16'h0001, 3'd0);
      send_op(CMD_ADC,   16'h0000, 16'h0000, 3'd0);
      send_op(CMD_SUB,   16'h0000, 16'h0001, 3'd0);
      send_op(CMD_SBC,   16'h0010, 16'h000F, 3'd0);
      send_op(CMD_CP,    16'h1234, 16'hFF34, 3'd0);
      send_op(CMD_AND,   16'hFFFF, 16'h0000, 3'd0);
      send_op(CMD_XOR,   16'hAAAA, 16'h55AA, 3'd0);
      send_op(CMD_OR,    16'h0000, 16'h0080, 3'd0);
      send_op(CMD_INC8,  16'hFFFF, 16'h0000, 3'd0);
      send_op(CMD_DEC8,  16'h0000, 16'h0000, 3'd0);
      send_op(CMD_RLC,   16'h0080, 16'h0000, 3'd0);
      send_op(CMD_RRC,   16'h0001, 16'h0000, 3'd0);
      send_op(CMD_RL,    16'h0080, 16'h0000, 3'd0);
      send_op(CMD_RR,    16'h0001, 16'h0000, 3'd0);
      send_op(CMD_SLA,   16'h0080, 16'h0000, 3'd0);
      send_op(CMD_SRA,   16'h0081, 16'h0000, 3'd0);
      send_op(CMD_SRL,   16'h0001, 16'h0000, 3'd0);
      send_op(CMD_SWAP,  16'hFFF0, 16'h0000, 3'd0);
      send_op(CMD_BIT,   16'hAB7F, 16'h0000, 3'd7);
      send_op(CMD_RES,   16'hFFFF, 16'h0000, 3'd0);
      send_op(CMD_SET,   16'h0000, 16'h0000, 3'd7);
      send_op(CMD_ADD,   16'h0099, 16'h0001, 3'd0);
      send_op(CMD_DAA,   16'h009A, 16'h0000, 3'd0);
      send_op(CMD_SUB,   16'h0010, 16'h0001, 3'd0);
      send_op(CMD_DAA,   16'h000F, 16'h0000, 3'd0);
      // adjust with a flag pattern the table does not list
      send_op(CMD_DAA,   16'h00F5, 16'h0000, 3'd0);
      send_op(CMD_RLCA,  16'h0000, 16'h0000, 3'd0);
      send_op(CMD_RLA,   16'h0080, 16'h0000, 3'd0);
      send_op(CMD_RRCA,  16'h0001, 16'h0000, 3'd0);
      send_op(CMD_RRA,   16'h0000, 16'h0000, 3'd0);
      send_op(CMD_ADD16, 16'hFFFF, 16'h0001, 3'd0);
      send_op(CMD_ADD16, 16'h0FFF, 16'h0001, 3'd0);
      send_op(CMD_INC16, 16'hFFFF, 16'h0000, 3'd0);
      send_op(CMD_DEC16, 16'h0000, 16'h0000, 3'd0);
      send_op(CMD_SPARE_FIRST, 16'hBEEF, 16'h1234, 3'd5);
      send_op(CMD_SPARE_LAST,  16'h0000, 16'hFFFF, 3'd2);

      // Random: sender idles less than receiver, then the reverse
      run_random_phase(140);
      send_idle_pct = 47;
      recv_idle_pct = 28;
      run_random_phase(140);

      // Full rate, opened by a long receiver hold-off to back up the pipe
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_requests++;
      run_random_phase(120);
      req_valid <= 1'b0;

      // Drain, then let any stray response show up
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
